/* design/vesc_pkg.sv */
`timescale 1ns / 1ps

package vesc_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] decoded_char;
		logic       outcome;
		logic       last;
	} out_item_t;

	// Sequence phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_BSLASH = 3'd1;
	localparam logic [2:0] PH_OCT1   = 3'd2;
	localparam logic [2:0] PH_OCT2   = 3'd3;
	localparam logic [2:0] PH_CARET  = 3'd4;
	localparam logic [2:0] PH_META   = 3'd5;
	localparam logic [2:0] PH_META_D = 3'd6;
	localparam logic [2:0] PH_META_C = 3'd7;

	// Outcome of decoding one byte.
	localparam logic [1:0] RES_NONE  = 2'd0;
	localparam logic [1:0] RES_VALID = 2'd1;
	localparam logic [1:0] RES_PUSH  = 2'd2;
	localparam logic [1:0] RES_ERROR = 2'd3;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOI  = 1'b1;

	localparam logic OUT_CHAR  = 1'b0;
	localparam logic OUT_ERROR = 1'b1;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] ESC_CHAR  = 8'h1B;

	// Output queue behind the decoder.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0] res;
		logic [7:0] ch;
		logic [2:0] phase;
		logic [5:0] accum;
	} step_t;

	typedef struct packed {
		logic [1:0] n;
		out_item_t  r0;
		out_item_t  r1;
	} push_t;

	typedef struct packed {
		push_t      push;
		logic [2:0] phase;
		logic [5:0] accum;
	} plan_t;

	function automatic step_t ctrl_letter(logic [7:0] b, logic hi);
		step_t r;
		r = '0;
		if (b == CH_QUEST) begin
			r.res = RES_VALID;
			r.ch  = {hi, 7'h7F};
		end else if (b < CH_AT || b[7]) begin
			r.res = RES_ERROR;
		end else begin
			r.res = RES_VALID;
			r.ch  = {hi, 2'b00, b[4:0]};
		end
		return r;
	endfunction

	function automatic step_t decode_byte(logic [2:0] ph, logic [5:0] acc, logic [7:0] b);
		step_t      r;
		step_t      c;
		logic       digit;
		logic [8:0] v;
		r       = '0;
		r.phase = PH_IDLE;
		r.accum = acc;
		digit   = (b >= CH_0) && (b <= CH_7);
		v       = {acc, b[2:0]};
		case (ph)
			PH_IDLE: begin
				if (b == CH_BSLASH) begin
					r.res   = RES_NONE;
					r.phase = PH_BSLASH;
				end else begin
					r.res = RES_VALID;
					r.ch  = b;
				end
			end
			PH_BSLASH: begin
				if (digit) begin
					r.accum = {3'b000, b[2:0]};
					r.phase = PH_OCT1;
				end else begin
					case (b)
						CH_CARET:  r.phase = PH_CARET;
						CH_M:      r.phase = PH_META;
						CH_DASH:   r.res = RES_NONE;
						CH_BSLASH: begin r.res = RES_VALID; r.ch = 8'h5C; end
						CH_N:      begin r.res = RES_VALID; r.ch = 8'h0A; end
						CH_R:      begin r.res = RES_VALID; r.ch = 8'h0D; end
						CH_B:      begin r.res = RES_VALID; r.ch = 8'h08; end
						CH_A:      begin r.res = RES_VALID; r.ch = 8'h07; end
						CH_V:      begin r.res = RES_VALID; r.ch = 8'h0B; end
						CH_T:      begin r.res = RES_VALID; r.ch = 8'h09; end
						CH_F:      begin r.res = RES_VALID; r.ch = 8'h0C; end
						CH_S:      begin r.res = RES_VALID; r.ch = 8'h20; end
						CH_E:      begin r.res = RES_VALID; r.ch = ESC_CHAR; end
						default:   r.res = RES_ERROR;
					endcase
				end
			end
			PH_OCT1, PH_OCT2: begin
				r.accum = '0;
				if (!digit) begin
					r.res = RES_PUSH;
					r.ch  = {2'b00, acc};
				end else if (ph == PH_OCT1) begin
					r.accum = v[5:0];
					r.phase = PH_OCT2;
				end else begin
					r.res = RES_VALID;
					r.ch  = v[7:0];
				end
			end
			PH_CARET: begin
				c     = ctrl_letter(b, 1'b0);
				r.res = c.res;
				r.ch  = c.ch;
			end
			PH_META: begin
				if (b == CH_CARET) begin
					r.phase = PH_META_C;
				end else if (b == CH_DASH) begin
					r.phase = PH_META_D;
				end else begin
					r.res = RES_ERROR;
				end
			end
			PH_META_D: begin
				r.res = RES_VALID;
				r.ch  = {1'b1, b[6:0]};
			end
			default: begin
				c     = ctrl_letter(b, 1'b1);
				r.res = c.res;
				r.ch  = c.ch;
			end
		endcase
		return r;
	endfunction

endpackage

/* design/vesc_decode.sv */
`timescale 1ns / 1ps

module vesc_decode
	import vesc_pkg::*;
(
	input  logic [2:0] phase,
	input  logic [5:0] accum,
	input  in_item_t   item,
	output plan_t      plan
);

	step_t p1;
	step_t p2;

	assign p1 = decode_byte(phase, accum, item.data_byte);
	// After an octal number is emitted the same byte is decoded again from idle.
	assign p2 = decode_byte(p1.phase, p1.accum, item.data_byte);

	always_comb begin
		plan = '0;
		plan.phase = PH_IDLE;
		plan.accum = '0;
		if (item.kind == KIND_EOI) begin
			if (phase == PH_OCT1 || phase == PH_OCT2) begin
				plan.push.n  = 2'd1;
				plan.push.r0 = '{decoded_char: {2'b00, accum}, outcome: OUT_CHAR, last: 1'b1};
			end else if (phase != PH_IDLE) begin
				plan.push.n  = 2'd1;
				plan.push.r0 = '{decoded_char: 8'h00, outcome: OUT_ERROR, last: 1'b1};
			end
		end else begin
			plan.phase = p1.phase;
			plan.accum = p1.accum;
			case (p1.res)
				RES_ERROR: begin
					plan.push.n  = 2'd1;
					plan.push.r0 = '{decoded_char: 8'h00, outcome: OUT_ERROR, last: 1'b1};
				end
				RES_VALID: begin
					plan.push.n  = 2'd1;
					plan.push.r0 = '{decoded_char: p1.ch, outcome: OUT_CHAR, last: 1'b1};
				end
				RES_PUSH: begin
					plan.phase   = p2.phase;
					plan.accum   = p2.accum;
					plan.push.r0 = '{decoded_char: p1.ch, outcome: OUT_CHAR, last: 1'b0};
					case (p2.res)
						RES_ERROR: begin
							plan.push.n  = 2'd2;
							plan.push.r1 = '{decoded_char: 8'h00, outcome: OUT_ERROR,
								last: 1'b1};
						end
						RES_VALID: begin
							plan.push.n  = 2'd2;
							plan.push.r1 = '{decoded_char: p2.ch, outcome: OUT_CHAR,
								last: 1'b1};
						end
						default: begin
							plan.push.n       = 2'd1;
							plan.push.r0.last = 1'b1;
						end
					endcase
				end
				default: begin
					plan.push.n = 2'd0;
				end
			endcase
		end
	end

endmodule

/* design/vesc_outq.sv */
`timescale 1ns / 1ps

module vesc_outq
	import vesc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	input  logic              pop,
	output logic [QCNT_W-1:0] count,
	output out_item_t         head
);

	out_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_ptr_nx1;

	assign wr_ptr_nx1 = wr_ptr_q + QPTR_W'(1);
	assign count      = count_q;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q  <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

/* design/visual_escape_decoder.sv */
`timescale 1ns / 1ps
// Visual escape decoder.
// Path: an accepted item is registered in the input stage; its results go into the output
// queue, a second result of an item together with the first, and are offered from there.
// Throughput: one item per cycle, limited by the two-entry output queue when an item
// gives two results or the consumer stalls.
// Reset clears the phase, the octal value and the queue pointers at once.

module visual_escape_decoder
	import vesc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      enc_valid,
	output logic      enc_stall,
	input  in_item_t  enc_item,
	output logic      dec_valid,
	input  logic      dec_stall,
	output out_item_t dec_item
);

	logic              valid_s1;
	in_item_t          item_s1;
	logic [2:0]        phase_q;
	logic [5:0]        accum_q;
	plan_t             plan;
	push_t             push;
	logic              pop;
	logic              advance;
	logic [QCNT_W-1:0] count;
	logic [QCNT_W:0]   need;
	logic [QCNT_W:0]   room;

	vesc_decode u_decode (
		.phase (phase_q),
		.accum (accum_q),
		.item  (item_s1),
		.plan  (plan)
	);

	assign pop       = dec_valid && !dec_stall;
	assign need      = (QCNT_W + 1)'(count) + (QCNT_W + 1)'(plan.push.n);
	assign room      = (QCNT_W + 1)'(QDEPTH) + (QCNT_W + 1)'(pop);
	assign advance   = valid_s1 && (need <= room);
	assign enc_stall = valid_s1 && !advance;

	always_comb begin
		push = plan.push;
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	vesc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.count  (count),
		.head   (dec_item)
	);

	assign dec_valid = (count != '0);

	always_ff @(posedge clk) begin
		if (!enc_stall && enc_valid) begin
			item_s1 <= enc_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			accum_q  <= '0;
		end else begin
			if (!enc_stall) begin
				valid_s1 <= enc_valid;
			end
			if (advance) begin
				phase_q <= plan.phase;
				accum_q <= plan.accum;
			end
		end
	end

endmodule

/* design/vesc_checker.sv */
`timescale 1ns / 1ps

module vesc_checker
	import vesc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      dec_valid,
	input logic      dec_stall,
	input out_item_t dec_item
);

	// A stalled result stays offered unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(dec_item))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_item.outcome == OUT_ERROR |-> dec_item.decoded_char == 8'h00)
		else $error("error result carries a character");

	// Only a flushed octal number can precede another result of the same item.
	a_first_char: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_item.last |-> dec_item.outcome == OUT_CHAR)
		else $error("non-final result is an error");

	// The second result of an item is queued together with the first.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !dec_stall && !dec_item.last |=> dec_valid)
		else $error("second result of an item missing");

endmodule

bind visual_escape_decoder vesc_checker u_vesc_checker (.*);

/* sim/visual_escape_decoder_test.sv */
`timescale 1ns / 1ps

module visual_escape_decoder_test;
	import vesc_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      enc_valid = 1'b0;
	logic      enc_stall;
	in_item_t  enc_item = '0;
	logic      dec_valid;
	logic      dec_stall = 1'b0;
	out_item_t dec_item;

	in_item_t  encoded_stream[$];
	out_item_t decoded_chars_due[$];

	// Escape state as the decoder should hold it.
	logic [2:0] esc_phase = PH_IDLE;
	logic [5:0] oct_val = '0;

	int mismatch_count = 0;
	bit in_taken = 1'b0;
	int burst_left = 30;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int run_cycles = 0;

	logic [7:0] named_letters[11] = '{CH_BSLASH, CH_N, CH_R, CH_B, CH_A, CH_V, CH_T, CH_F,
		CH_S, CH_E, CH_DASH};

	visual_escape_decoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc_item (enc_item),
		.dec_valid(dec_valid),
		.dec_stall(dec_stall),
		.dec_item (dec_item)
	);

	always #1 clk = ~clk;

	// Control character for a caret form; bit 8 flags a byte that has none.
	function automatic logic [8:0] caret_char(logic [7:0] b, logic hi);
		if (b == CH_QUEST)
			return {1'b0, hi, 7'h7F};
		if (b < CH_AT || b > 8'h7F)
			return 9'h100;
		return {1'b0, hi, 2'b00, b[4:0]};
	endfunction

	function automatic out_item_t make_result(logic [1:0] res, logic [7:0] ch);
		out_item_t r;
		r.decoded_char = (res == RES_ERROR) ? 8'h00 : ch;
		r.outcome      = (res == RES_ERROR) ? OUT_ERROR : OUT_CHAR;
		r.last         = 1'b0;
		return r;
	endfunction

	task automatic decode_escape_byte(input logic [7:0] b, output logic [1:0] res,
		output logic [7:0] ch);
		logic [2:0] ph;
		logic       is_digit;
		logic [8:0] num;
		logic [8:0] ctl;
		ph        = esc_phase;
		is_digit  = (b >= CH_0) && (b <= CH_7);
		num       = {3'b000, oct_val} * 9'd8 + 9'(b - CH_0);
		res       = RES_NONE;
		ch        = 8'h00;
		esc_phase = PH_IDLE;
		case (ph)
			PH_IDLE: begin
				if (b == CH_BSLASH) begin
					esc_phase = PH_BSLASH;
				end else begin
					res = RES_VALID;
					ch  = b;
				end
			end
			PH_BSLASH: begin
				if (is_digit) begin
					oct_val   = 6'(b - CH_0);
					esc_phase = PH_OCT1;
				end else if (b == CH_CARET) begin
					esc_phase = PH_CARET;
				end else if (b == CH_M) begin
					esc_phase = PH_META;
				end else if (b != CH_DASH) begin
					res = RES_VALID;
					case (b)
						CH_BSLASH: ch = 8'h5C;
						CH_N:      ch = 8'h0A;
						CH_R:      ch = 8'h0D;
						CH_B:      ch = 8'h08;
						CH_A:      ch = 8'h07;
						CH_V:      ch = 8'h0B;
						CH_T:      ch = 8'h09;
						CH_F:      ch = 8'h0C;
						CH_S:      ch = 8'h20;
						CH_E:      ch = 8'h1B;
						default:   res = RES_ERROR;
					endcase
				end
			end
			PH_OCT1, PH_OCT2: begin
				if (!is_digit) begin
					res     = RES_PUSH;
					ch      = {2'b00, oct_val};
					oct_val = '0;
				end else if (ph == PH_OCT1) begin
					oct_val   = num[5:0];
					esc_phase = PH_OCT2;
				end else begin
					res     = RES_VALID;
					ch      = num[7:0];
					oct_val = '0;
				end
			end
			PH_META: begin
				if (b == CH_CARET)
					esc_phase = PH_META_C;
				else if (b == CH_DASH)
					esc_phase = PH_META_D;
				else
					res = RES_ERROR;
			end
			PH_META_D: begin
				res = RES_VALID;
				ch  = b | 8'h80;
			end
			default: begin
				ctl = caret_char(b, ph == PH_META_C);
				res = ctl[8] ? RES_ERROR : RES_VALID;
				ch  = ctl[7:0];
			end
		endcase
	endtask

	task automatic put_byte(input logic [7:0] b);
		in_item_t it;
		it.kind      = KIND_DATA;
		it.data_byte = b;
		encoded_stream.push_back(it);
	endtask

	task automatic put_eoi();
		in_item_t it;
		it.kind      = KIND_EOI;
		it.data_byte = 8'($urandom_range(0, 255));
		encoded_stream.push_back(it);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	function automatic logic [7:0] caret_operand();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			return CH_QUEST;
		if (pick < 14)
			return 8'($urandom_range(8'h40, 8'h7F));
		return 8'($urandom_range(0, 255));
	endfunction

	// One plain byte or escape sequence with random content, now and then cut short by an end of input.
	task automatic queue_random_escape();
		logic [7:0] seq[$];
		int         pick;
		int         cut;
		int         n;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			seq.push_back(CH_BSLASH);
			if (pick < 35) begin
				seq.push_back(named_letters[$urandom_range(0, 10)]);
			end else if (pick < 55) begin
				n = $urandom_range(1, 3);
				repeat (n) seq.push_back(CH_0 + 8'($urandom_range(0, 7)));
			end else if (pick < 65) begin
				seq.push_back(CH_CARET);
				seq.push_back(caret_operand());
			end else if (pick < 75) begin
				seq.push_back(CH_M);
				seq.push_back(CH_DASH);
				seq.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				seq.push_back(CH_M);
				seq.push_back(CH_CARET);
				seq.push_back(caret_operand());
			end else begin
				if ($urandom_range(0, 1) == 1)
					seq.push_back(CH_M);
				seq.push_back(8'($urandom_range(0, 255)));
			end
		end
		cut = seq.size();
		if (seq.size() > 1 && $urandom_range(0, 11) == 0)
			cut = $urandom_range(1, seq.size() - 1);
		for (int i = 0; i < cut; i++)
			put_byte(seq[i]);
		if (cut < seq.size() || $urandom_range(0, 24) == 0)
			put_eoi();
	endtask

	always @(negedge clk) begin
		if (arst_n && (!enc_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left  <= gap_left - 1;
				enc_valid <= 1'b0;
			end else if (encoded_stream.size() != 0) begin
				enc_item  <= encoded_stream.pop_front();
				enc_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				enc_valid <= 1'b0;
			end
		end
	end

	// The long hold-offs let the decoder fill up and push back on the sender.
	always @(negedge clk) begin
		run_cycles <= run_cycles + 1;
		if (run_cycles == 600 || run_cycles == 1500) begin
			hold_left <= 50;
			dec_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dec_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(20, 120);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       dec_stall <= 1'b0;
				1:       dec_stall <= ($urandom_range(0, 1) == 1);
				2:       dec_stall <= (run_cycles % 3 == 0);
				default: dec_stall <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t  want;
		out_item_t  got[2];
		int         n_got;
		logic [1:0] res;
		logic [7:0] ch;
		if (arst_n) begin
			in_taken <= enc_valid && !enc_stall;
			if (dec_valid && !dec_stall) begin
				if (decoded_chars_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("Unexpected item: char %02h outcome %0d last %0d",
							dec_item.decoded_char, dec_item.outcome, dec_item.last);
					mismatch_count++;
				end else begin
					want = decoded_chars_due.pop_front();
					if (dec_item.decoded_char !== want.decoded_char
						|| dec_item.outcome !== want.outcome
						|| dec_item.last !== want.last) begin
						if (mismatch_count < 10)
							$display({"Mismatch: expected char %02h outcome %0d last %0d,",
								" got char %02h outcome %0d last %0d"},
								want.decoded_char, want.outcome, want.last,
								dec_item.decoded_char, dec_item.outcome, dec_item.last);
						mismatch_count++;
					end
				end
			end
			if (enc_valid && !enc_stall) begin
				n_got = 0;
				if (enc_item.kind == KIND_EOI) begin
					if (esc_phase == PH_OCT1 || esc_phase == PH_OCT2) begin
						got[0] = make_result(RES_VALID, {2'b00, oct_val});
						n_got  = 1;
					end else if (esc_phase != PH_IDLE) begin
						got[0] = make_result(RES_ERROR, 8'h00);
						n_got  = 1;
					end
					esc_phase = PH_IDLE;
					oct_val   = '0;
				end else begin
					decode_escape_byte(enc_item.data_byte, res, ch);
					if (res != RES_NONE) begin
						got[n_got] = make_result(res, ch);
						n_got++;
					end
					// The byte that ended a short octal number starts over from idle.
					if (res == RES_PUSH) begin
						decode_escape_byte(enc_item.data_byte, res, ch);
						if (res != RES_NONE) begin
							got[n_got] = make_result(res, ch);
							n_got++;
						end
					end
				end
				for (int i = 0; i < n_got; i++) begin
					got[i].last = (i == n_got - 1);
					decoded_chars_due.push_back(got[i]);
				end
			end
		end
	end

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		put_byte(8'h00);
		put_byte(8'hFF);
		put_str("\\777");
		put_str("\\3A");
		put_str("\\^?");
		put_str("\\M^@");
		put_str("\\M-");
		put_byte(8'hFF);
		put_str("\\z");
		put_str("\\-");
		put_eoi();
		put_str("\\12");
		put_eoi();
		put_str("\\^");
		put_eoi();
		while (encoded_stream.size() < 1900)
			queue_random_escape();

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (encoded_stream.size() != 0 || enc_valid)
			@(posedge clk);
		while (decoded_chars_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
design/vesc_pkg.sv
design/vesc_decode.sv
design/vesc_outq.sv
design/visual_escape_decoder.sv
design/vesc_checker.sv
sim/visual_escape_decoder_test.sv
